### rtl/core/scope_capture_trigger_measure_macros.svh
// Assertion macros for the scope capture, trigger and measure block.
// Included by the top level; expects clk and rst in scope at the point of use.
`ifndef SCOPE_CAPTURE_TRIGGER_MEASURE_MACROS_SVH
`define SCOPE_CAPTURE_TRIGGER_MEASURE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCM_ASSERT_NOW(lbl, ante, cons, msg)
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/scm_pkg.sv
// Shared types, constants and scaling tables for the scope capture block.
// No dependencies; used by every module in rtl/core except scm_queue.
`default_nettype none
package scm_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int ROW_W       = 11;
  localparam int LEVEL_W     = 8;
  localparam int RANGE_W     = 2;
  localparam int TRIG_W      = 7;
  localparam int GAP_W       = 9;
  localparam int GAIN_W      = 10;
  localparam int PROD_W      = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 32;
  localparam int QPROD_W     = PROD_W + RECIP_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // ceil(2^32 / 1000); exact floor(d / 1000) for every d below 2^22
  localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294968;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 12'h000;

  localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_RANGE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL  = 1'b1;

  localparam logic [RANGE_W-1:0] RANGE_0V5 = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_1V  = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_2V  = 2'd2;
  localparam logic [RANGE_W-1:0] RANGE_4V  = 2'd3;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_2V;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd100;

  localparam logic [TRIG_W-1:0] TRIG_DEFAULT = 7'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] disp_max;
    logic [SAMPLE_W-1:0] disp_min;
    logic [TRIG_W-1:0]   trig;
  } job_t;

  // gain in thousandths
  function automatic logic [GAIN_W-1:0] gain_milli(input logic [RANGE_W-1:0] sel);
    logic [GAIN_W-1:0] g;
    unique case (sel)
      RANGE_0V5: g = 10'd565;
      RANGE_1V:  g = 10'd300;
      RANGE_2V:  g = 10'd163;
      RANGE_4V:  g = 10'd65;
      default:   g = 10'd163;
    endcase
    return g;
  endfunction

  // row offset times 1000
  function automatic logic [PROD_W-1:0] offset_milli(input logic [RANGE_W-1:0] sel);
    logic [PROD_W-1:0] f;
    unique case (sel)
      RANGE_0V5: f = 22'd1154000;
      RANGE_1V:  f = 22'd671000;
      RANGE_2V:  f = 22'd420000;
      RANGE_4V:  f = 22'd240000;
      default:   f = 22'd420000;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

### rtl/core/scope_capture_trigger_measure.sv
// Flow: the front takes one sample per cycle while the store is free and no capture drains;
// after the last sample the row pipeline and hand-off pass the capture to the queue, and the
// back reads the stored samples until the downward crossing or the last sample; input
// reopens once the scan ends.
// The next capture is taken while the finished result waits in the output register.
// Reset (rst, synchronous) clears control and capture state; the store is not cleared.
`default_nettype none
`include "scope_capture_trigger_measure_macros.svh"
module scope_capture_trigger_measure #(
  parameter int SAMPLE_DEPTH   = 512,
  parameter int DISPLAY_WIDTH  = 240,
  parameter int TRIGGER_WINDOW = 80
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // sample[11:0]
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // max_sample[11:0], min_sample[23:12], trigger_index[30:24], edge_gap[39:31]
  output logic      [39:0]                       m_axis_tdata,
  output logic                                   m_axis_tuser,  // gap_valid
  input  wire logic                              cfg_we,
  input  wire logic [scm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int CW    = $clog2(SAMPLE_DEPTH + 1);
  localparam int JOB_W = $bits(scm_pkg::job_t);

  logic [scm_pkg::RANGE_W-1:0]  vertical_range;
  logic [scm_pkg::LEVEL_W-1:0]  trig_level;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [scm_pkg::SAMPLE_W-1:0] wr_data;
  logic [AW-1:0]                rd_addr;
  logic [scm_pkg::SAMPLE_W-1:0] rd_data;

  logic                         f_job_valid;
  logic                         f_job_ready;
  scm_pkg::job_t                f_job;
  logic [CW-1:0]                f_job_count;
  logic                         q_valid;
  logic                         q_ready;
  logic [JOB_W+CW-1:0]          q_data;
  scm_pkg::job_t                q_job;
  logic                         back_busy;
  logic                         store_busy;
  logic                         q_push;

  logic [scm_pkg::SAMPLE_W-1:0] res_max;
  logic [scm_pkg::SAMPLE_W-1:0] res_min;
  logic [scm_pkg::TRIG_W-1:0]   res_trig;
  logic [scm_pkg::GAP_W-1:0]    res_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_range <= scm_pkg::RANGE_RESET;
      trig_level     <= scm_pkg::LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scm_pkg::REG_VERTICAL_RANGE: vertical_range <= cfg_data[scm_pkg::RANGE_W-1:0];
        scm_pkg::REG_TRIGGER_LEVEL:  trig_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // store stays with the queued or scanning capture until its scan ends
  assign store_busy = q_valid || back_busy;
  assign q_push     = f_job_valid && f_job_ready;
  assign q_job      = q_data[JOB_W-1:0];

  scm_front #(
    .SAMPLE_DEPTH   (SAMPLE_DEPTH),
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .TRIGGER_WINDOW (TRIGGER_WINDOW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_sample      (s_axis_tdata[scm_pkg::SAMPLE_W-1:0]),
    .in_last        (s_axis_tlast),
    .vertical_range (vertical_range),
    .trig_level     (trig_level),
    .store_busy     (store_busy),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .job_valid      (f_job_valid),
    .job_ready      (f_job_ready),
    .job            (f_job),
    .job_count      (f_job_count)
  );

  scm_store #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scm_queue #(
    .W (JOB_W + CW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_job_valid),
    .push_ready (f_job_ready),
    .push_data  ({f_job_count, f_job}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  scm_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_valid),
    .job_ready     (q_ready),
    .job           (q_job),
    .job_count     (q_data[JOB_W +: CW]),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (back_busy),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_max       (res_max),
    .out_min       (res_min),
    .out_trig      (res_trig),
    .out_gap       (res_gap),
    .out_gap_valid (m_axis_tuser)
  );

  assign m_axis_tdata = {res_gap, res_trig, res_min, res_max};

  `SCM_ASSERT_NOW(a_scan_blocks_input, back_busy, !s_axis_tready, "input open during scan")
  `SCM_ASSERT_NEXT(a_hold_after_push, q_push, !s_axis_tready, "input open after hand-off")
  `SCM_ASSERT_NOW(a_result_from_scan, $rose(m_axis_tvalid), $past(back_busy), "result without scan")
  `SCM_ASSERT_NOW(a_trig_nonzero, m_axis_tvalid, m_axis_tdata[30:24] != 7'd0, "trigger index zero")

endmodule
`default_nettype wire

### rtl/core/scm_store.sv
// Sample memory: one write port for the front, one registered read port for the back.
// Depends on scm_pkg for the sample width.
`default_nettype none
module scm_store #(
  parameter int SAMPLE_DEPTH = 512
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(SAMPLE_DEPTH)-1:0]     wr_addr,
  input  wire logic [scm_pkg::SAMPLE_W-1:0]        wr_data,
  input  wire logic [$clog2(SAMPLE_DEPTH)-1:0]     rd_addr,
  output logic      [scm_pkg::SAMPLE_W-1:0]        rd_data
);

  logic [scm_pkg::SAMPLE_W-1:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/core/scm_queue.sv
// Two-entry job queue between the capture front and the measure back.
// Generic payload width; no package dependency.
`default_nettype none
module scm_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic      [W-1:0] pop_data
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   used;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (used != 2'd2);
  assign pop_valid  = (used != 2'd0);
  assign pop_data   = slot[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      used <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      if (do_push && !do_pop) begin
        used <= used + 2'd1;
      end else if (do_pop && !do_push) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/scm_front.sv
// Capture front: accepts samples, writes the store, tracks extremes, scales rows
// and searches the trigger; hands a finished capture to the queue. Uses scm_pkg.
`default_nettype none
module scm_front #(
  parameter int SAMPLE_DEPTH   = 512,
  parameter int DISPLAY_WIDTH  = 240,
  parameter int TRIGGER_WINDOW = 80
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [scm_pkg::SAMPLE_W-1:0]          in_sample,
  input  wire logic                                  in_last,
  input  wire logic [scm_pkg::RANGE_W-1:0]           vertical_range,
  input  wire logic [scm_pkg::LEVEL_W-1:0]           trig_level,
  input  wire logic                                  store_busy,
  output logic                                       wr_en,
  output logic      [$clog2(SAMPLE_DEPTH)-1:0]       wr_addr,
  output logic      [scm_pkg::SAMPLE_W-1:0]          wr_data,
  output logic                                       job_valid,
  input  wire logic                                  job_ready,
  output scm_pkg::job_t                              job,
  output logic      [$clog2(SAMPLE_DEPTH+1)-1:0]     job_count
);

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int TIW = $clog2(TRIGGER_WINDOW + 1);

  logic [CW-1:0]                count;
  logic [scm_pkg::SAMPLE_W-1:0] cap_max;
  logic [scm_pkg::SAMPLE_W-1:0] cap_min;
  logic [scm_pkg::SAMPLE_W-1:0] disp_max;
  logic [scm_pkg::SAMPLE_W-1:0] disp_min;
  logic [scm_pkg::ROW_W-1:0]    prev_row;
  logic [TIW-1:0]               trig;
  logic                         drain;
  logic                         push_pend;

  logic                         acc;
  logic                         store;
  logic                         push;
  logic [scm_pkg::SAMPLE_W:0]   mid_sum;
  logic [scm_pkg::PROD_W-1:0]   offset;
  logic [scm_pkg::QPROD_W-1:0]  qprod;
  logic                         trig_hit;

  // row pipeline: multiply, absolute difference, reciprocal multiply
  logic                         p1_st, p1_lst, p2_st, p2_lst, p3_st, p3_lst;
  logic [CW-1:0]                p1_n, p2_n, p3_n;
  logic [scm_pkg::PROD_W-1:0]   p1_prod;
  logic [scm_pkg::PROD_W-1:0]   p2_diff;
  logic [scm_pkg::ROW_W-1:0]    p3_row;

  assign in_ready = !drain && !store_busy;
  assign acc      = in_valid && in_ready;
  assign store    = acc && (32'(count) < SAMPLE_DEPTH);
  assign push     = job_valid && job_ready;

  assign wr_en   = store;
  assign wr_addr = count[AW-1:0];
  assign wr_data = in_sample;

  assign offset = scm_pkg::offset_milli(vertical_range);
  assign qprod  = scm_pkg::QPROD_W'(p2_diff) * scm_pkg::QPROD_W'(scm_pkg::RECIP_1000);

  assign trig_hit = p3_st && (p3_n != '0) && (32'(p3_n) <= TRIGGER_WINDOW) &&
                    (trig == '0) &&
                    (prev_row >= scm_pkg::ROW_W'(trig_level)) &&
                    (p3_row < scm_pkg::ROW_W'(trig_level));

  assign mid_sum       = {1'b0, cap_max} + {1'b0, cap_min};
  assign job_valid     = push_pend;
  assign job.mid       = mid_sum[scm_pkg::SAMPLE_W:1];
  assign job.disp_max  = disp_max;
  assign job.disp_min  = disp_min;
  assign job.trig      = (trig == '0) ? scm_pkg::TRIG_DEFAULT : scm_pkg::TRIG_W'(trig);
  assign job_count     = count;

  always_ff @(posedge clk) begin
    p1_n    <= count;
    p1_prod <= scm_pkg::PROD_W'(in_sample) *
               scm_pkg::PROD_W'(scm_pkg::gain_milli(vertical_range));
    p2_n    <= p1_n;
    p2_diff <= (p1_prod >= offset) ? (p1_prod - offset) : (offset - p1_prod);
    p3_n    <= p2_n;
    p3_row  <= qprod[scm_pkg::RECIP_SHIFT +: scm_pkg::ROW_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_st  <= 1'b0;
      p1_lst <= 1'b0;
      p2_st  <= 1'b0;
      p2_lst <= 1'b0;
      p3_st  <= 1'b0;
      p3_lst <= 1'b0;
    end else begin
      p1_st  <= store;
      p1_lst <= acc && in_last;
      p2_st  <= p1_st;
      p2_lst <= p1_lst;
      p3_st  <= p2_st;
      p3_lst <= p2_lst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap_max   <= scm_pkg::SAMPLE_MIN;
      cap_min   <= scm_pkg::SAMPLE_MAX;
      disp_max  <= scm_pkg::SAMPLE_MIN;
      disp_min  <= scm_pkg::SAMPLE_MAX;
      prev_row  <= '0;
      trig      <= '0;
      drain     <= 1'b0;
      push_pend <= 1'b0;
    end else if (push) begin
      // capture handed off: clear for the next one
      count     <= '0;
      cap_max   <= scm_pkg::SAMPLE_MIN;
      cap_min   <= scm_pkg::SAMPLE_MAX;
      disp_max  <= scm_pkg::SAMPLE_MIN;
      disp_min  <= scm_pkg::SAMPLE_MAX;
      prev_row  <= '0;
      trig      <= '0;
      drain     <= 1'b0;
      push_pend <= 1'b0;
    end else begin
      if (acc && in_last) drain <= 1'b1;
      if (store) begin
        count <= count + 1'b1;
        if (in_sample > cap_max) cap_max <= in_sample;
        if (in_sample < cap_min) cap_min <= in_sample;
        if (32'(count) < DISPLAY_WIDTH) begin
          if (in_sample > disp_max) disp_max <= in_sample;
          if (in_sample < disp_min) disp_min <= in_sample;
        end
      end
      if (p3_st) prev_row <= p3_row;
      if (trig_hit) trig <= TIW'(p3_n);
      if (p3_lst) push_pend <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/scm_back.sv
// Measure back: scans the stored capture for the mid crossings and holds the
// finished result in an output register. Uses scm_pkg.
`default_nettype none
module scm_back #(
  parameter int SAMPLE_DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  job_valid,
  output logic                                       job_ready,
  input  wire scm_pkg::job_t                         job,
  input  wire logic [$clog2(SAMPLE_DEPTH+1)-1:0]     job_count,
  output logic      [$clog2(SAMPLE_DEPTH)-1:0]       rd_addr,
  input  wire logic [scm_pkg::SAMPLE_W-1:0]          rd_data,
  output logic                                       busy,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [scm_pkg::SAMPLE_W-1:0]          out_max,
  output logic      [scm_pkg::SAMPLE_W-1:0]          out_min,
  output logic      [scm_pkg::TRIG_W-1:0]            out_trig,
  output logic      [scm_pkg::GAP_W-1:0]             out_gap,
  output logic                                       out_gap_valid
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int CW = $clog2(SAMPLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } back_state_t;

  back_state_t                  state;
  back_state_t                  state_next;
  scm_pkg::job_t                cur;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                rp;
  logic                         rd_valid;
  logic [CW-1:0]                rd_idx;
  logic [scm_pkg::SAMPLE_W-1:0] w0;
  logic [scm_pkg::SAMPLE_W-1:0] w1;
  logic                         up;
  logic [CW-1:0]                first;

  logic                         pop;
  logic                         issue;
  logic                         proc;
  logic                         eval;
  logic [CW-1:0]                idx;
  logic                         hit_up;
  logic                         hit_down;
  logic                         done;

  assign busy      = (state == ST_SCAN);
  assign job_ready = (state == ST_IDLE) && !out_valid;
  assign pop       = job_valid && job_ready;
  assign issue     = busy && (rp < cnt);
  assign rd_addr   = rp[AW-1:0];
  assign proc      = busy && rd_valid;
  assign eval      = proc && (32'(rd_idx) >= 2);
  assign idx       = rd_idx - 1'b1;
  assign hit_up    = eval && !up && (w0 < cur.mid) && (rd_data > cur.mid);
  assign hit_down  = eval && up && (w0 > cur.mid) && (rd_data < cur.mid);
  // stop on the second crossing, on the last stored sample, or on a short capture
  assign done      = busy && ((32'(cnt) < 3) || hit_down ||
                              (proc && (rd_idx == cnt - 1'b1)));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (pop)  state_next = ST_SCAN;
      ST_SCAN: if (done) state_next = ST_IDLE;
      default:           state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
      cnt <= job_count;
    end
    rd_idx <= rp;
    if (proc) begin
      w0 <= w1;
      w1 <= rd_data;
    end
    if (hit_up) first <= idx;
    if (done) begin
      out_max       <= cur.disp_max;
      out_min       <= cur.disp_min;
      out_trig      <= cur.trig;
      out_gap       <= hit_down ? scm_pkg::GAP_W'(idx - first) : '0;
      out_gap_valid <= hit_down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rp        <= '0;
      rd_valid  <= 1'b0;
      up        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (pop) begin
        rp <= '0;
        up <= 1'b0;
      end else if (issue) begin
        rp <= rp + 1'b1;
      end
      if (hit_up) up <= 1'b1;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
